// ===== rtl/core/rsch_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_pkg: shared types and constants for the send count histogram
// Field widths, item kinds, register indexes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsch_pkg;

	// Fixed field widths
	localparam int KIND_W     = 3;
	localparam int SLOT_W     = 8;
	localparam int VAL_W      = 32;
	localparam int GIDX_W     = 32;
	localparam int RANK_W     = 8;
	localparam int CHUNK_W    = 4;
	localparam int COUNT_W    = 32;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;

	// Parameter defaults
	localparam int DEF_MAX_CHUNKS = 16;
	localparam int DEF_MAX_RANKS  = 256;
	localparam int DEF_INDEX_BITS = 32;

	// Item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_OFS  = 3'd0,
		KIND_LOAD_RANK = 3'd1,
		KIND_CLEAR     = 3'd2,
		KIND_CLASSIFY  = 3'd3,
		KIND_READ      = 3'd4
	} kind_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_CHUNKS = 2'd0,
		CFG_COL_CHUNKS = 2'd1
	} cfg_reg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_LOOK,
		ST_CHK,
		ST_UPD,
		ST_RD,
		ST_RDOUT
	} state_t;

	// Which result the output register is loaded with
	typedef enum logic [1:0] {
		RES_MISS,
		RES_BADRANK,
		RES_COUNT,
		RES_READ
	} res_sel_t;

	typedef struct packed {
		logic     wr_ofs;
		logic     wr_rank;
		logic     clear;
		logic     start_scan;
		logic     start_read;
		logic     scan;
		logic     calc;
		logic     use_slot;
		logic     emit;
		res_sel_t res_sel;
		logic     cnt_write;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic rank_ok;
		logic out_full;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rsch_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_if: channel interfaces of the send count histogram
// Request channel, result channel and register write channel, each with
// valid/ready and its payload.
// ----------------------------------------------------------------------------
interface rsch_req_if;
	import rsch_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              table_axis;
	logic [SLOT_W-1:0] entry_index;
	logic [VAL_W-1:0]  entry_value;
	logic [GIDX_W-1:0] global_row;
	logic [GIDX_W-1:0] global_col;

	modport source (output valid, kind, table_axis, entry_index, entry_value,
		global_row, global_col, input ready);
	modport sink (input valid, kind, table_axis, entry_index, entry_value,
		global_row, global_col, output ready);
endinterface

interface rsch_rsp_if;
	import rsch_pkg::*;
	logic               valid;
	logic               ready;
	logic [RANK_W-1:0]  dest_rank;
	logic [CHUNK_W-1:0] row_chunk;
	logic [CHUNK_W-1:0] col_chunk;
	logic [COUNT_W-1:0] count_value;
	logic               out_of_range;

	modport source (output valid, dest_rank, row_chunk, col_chunk, count_value,
		out_of_range, input ready);
	modport sink (input valid, dest_rank, row_chunk, col_chunk, count_value,
		out_of_range, output ready);
endinterface

interface rsch_cfg_if;
	import rsch_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsch_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_ctrl: sequencing controller
// Decodes request kinds, walks the chunk scan, rank lookup and count
// update, and hands each result to the output register when it is free.
// ----------------------------------------------------------------------------
module rsch_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [rsch_pkg::KIND_W-1:0] req_kind,
	output logic                      req_ready,
	input  rsch_pkg::sts_t            sts,
	output rsch_pkg::cmd_t            cmd
);
	import rsch_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = RES_MISS;
		req_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_kind)
						KIND_LOAD_OFS:  cmd.wr_ofs  = 1'b1;
						KIND_LOAD_RANK: cmd.wr_rank = 1'b1;
						KIND_CLEAR:     cmd.clear   = 1'b1;
						KIND_CLASSIFY: begin
							cmd.start_scan = 1'b1;
							state_d        = ST_SCAN;
						end
						KIND_READ: begin
							cmd.start_read = 1'b1;
							state_d        = ST_RD;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				priority if (!sts.hit) begin
					if (!sts.out_full) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_MISS;
						state_d     = ST_IDLE;
					end
				end else if (!sts.rank_ok) begin
					if (!sts.out_full) begin
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_BADRANK;
						state_d     = ST_IDLE;
					end
				end else begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (!sts.out_full) begin
					cmd.emit      = 1'b1;
					cmd.res_sel   = RES_COUNT;
					cmd.cnt_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.use_slot = 1'b1;
				state_d      = ST_RDOUT;
			end
			ST_RDOUT: begin
				cmd.use_slot = 1'b1;
				if (!sts.out_full) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_READ;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/rsch_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsch_dpath: tables, chunk scan, count update and output register
// Offset, rank and count tables are memories with registered reads. The
// chunk scan reads one offset per axis each cycle and checks one interval.
// ----------------------------------------------------------------------------
module rsch_dpath #(
	parameter int MAX_CHUNKS = rsch_pkg::DEF_MAX_CHUNKS,
	parameter int MAX_RANKS  = rsch_pkg::DEF_MAX_RANKS,
	parameter int INDEX_BITS = rsch_pkg::DEF_INDEX_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsch_pkg::cmd_t                cmd,
	output rsch_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic [rsch_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsch_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          req_table_axis,
	input  logic [rsch_pkg::SLOT_W-1:0]   req_entry_index,
	input  logic [rsch_pkg::VAL_W-1:0]    req_entry_value,
	input  logic [rsch_pkg::GIDX_W-1:0]   req_global_row,
	input  logic [rsch_pkg::GIDX_W-1:0]   req_global_col,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [rsch_pkg::RANK_W-1:0]   rsp_dest_rank,
	output logic [rsch_pkg::CHUNK_W-1:0]  rsp_row_chunk,
	output logic [rsch_pkg::CHUNK_W-1:0]  rsp_col_chunk,
	output logic [rsch_pkg::COUNT_W-1:0]  rsp_count_value,
	output logic                          rsp_out_of_range
);
	import rsch_pkg::*;

	localparam int OT_D  = MAX_CHUNKS + 1;
	localparam int OA_W  = $clog2(OT_D);
	localparam int OFS_W = (INDEX_BITS < GIDX_W) ? INDEX_BITS : GIDX_W;
	localparam int RT_D  = (MAX_RANKS < (2 ** SLOT_W)) ? MAX_RANKS : (2 ** SLOT_W);
	localparam int RA_W  = $clog2(RT_D);
	localparam int FW    = 2 * OA_W;

	// Config registers and clamped chunk counts
	logic [CFG_W-1:0] row_chunks_q, col_chunks_q;
	logic [OA_W-1:0]  nr, nc, nmax;

	// Tables
	logic [OFS_W-1:0]   row_mem [OT_D];
	logic [OFS_W-1:0]   col_mem [OT_D];
	logic [RANK_W-1:0]  rank_mem [RT_D];
	logic [COUNT_W-1:0] cnt_mem [RT_D];
	logic [RT_D-1:0]    cnt_vld_q;

	// Scan state
	logic [OFS_W-1:0] idx_row_q, idx_col_q;
	logic [OA_W-1:0]  k_q, j_s1;
	logic             v_s1;
	logic [OFS_W-1:0] rrow_s1, rcol_s1, prev_row_q, prev_col_q;
	logic             found_row_q, found_col_q;
	logic [OA_W-1:0]  rc_q, cc_q;
	logic             row_hit, col_hit, chk_en;

	// Lookup and count
	logic [FW-1:0]      flat_d, flat_q;
	logic               hit_q;
	logic [RANK_W-1:0]  rank_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [RA_W-1:0]    cnt_addr;
	logic [COUNT_W-1:0] cnt_rd_q, cnt_base, cnt_next;
	logic               cvld_rd_q;
	logic               ofs_we, rank_we, slot_ok;

	// Output register
	logic               out_valid_q;
	logic [RANK_W-1:0]  res_dest_q;
	logic [CHUNK_W-1:0] res_row_q, res_col_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               res_oor_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_chunks_q <= CFG_W'(1);
			col_chunks_q <= CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROW_CHUNKS) row_chunks_q <= cfg_wdata;
			if (cfg_index == CFG_COL_CHUNKS) col_chunks_q <= cfg_wdata;
		end
	end

	// Clamp chunk counts to 1..MAX_CHUNKS
	always_comb begin
		priority if (row_chunks_q == '0) nr = OA_W'(1);
		else if (32'(row_chunks_q) > MAX_CHUNKS) nr = OA_W'(MAX_CHUNKS);
		else nr = OA_W'(row_chunks_q);
		priority if (col_chunks_q == '0) nc = OA_W'(1);
		else if (32'(col_chunks_q) > MAX_CHUNKS) nc = OA_W'(MAX_CHUNKS);
		else nc = OA_W'(col_chunks_q);
		nmax = (nr > nc) ? nr : nc;
	end

	assign ofs_we  = cmd.wr_ofs && (32'(req_entry_index) <= MAX_CHUNKS);
	assign rank_we = cmd.wr_rank && (32'(req_entry_index) < MAX_RANKS);

	// Offset tables: one write port, one scan read port each
	always_ff @(posedge clk) begin
		if (ofs_we && !req_table_axis) row_mem[OA_W'(req_entry_index)] <= req_entry_value[OFS_W-1:0];
		if (ofs_we && req_table_axis)  col_mem[OA_W'(req_entry_index)] <= req_entry_value[OFS_W-1:0];
		rrow_s1 <= row_mem[k_q];
		rcol_s1 <= col_mem[k_q];
	end

	// Interval check for chunk j_s1-1 on both axes
	assign chk_en  = cmd.scan && v_s1 && (j_s1 != '0);
	assign row_hit = chk_en && (j_s1 <= nr) && !found_row_q &&
		(prev_row_q <= idx_row_q) && (idx_row_q < rrow_s1);
	assign col_hit = chk_en && (j_s1 <= nc) && !found_col_q &&
		(prev_col_q <= idx_col_q) && (idx_col_q < rcol_s1);
	assign sts.scan_done = cmd.scan && v_s1 && (j_s1 == nmax);

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			v_s1        <= 1'b0;
			found_row_q <= 1'b0;
			found_col_q <= 1'b0;
		end else begin
			v_s1 <= cmd.scan;
			if (cmd.start_scan) begin
				k_q         <= '0;
				found_row_q <= 1'b0;
				found_col_q <= 1'b0;
			end else begin
				if (cmd.scan && (k_q < nmax)) k_q <= k_q + OA_W'(1);
				if (row_hit) found_row_q <= 1'b1;
				if (col_hit) found_col_q <= 1'b1;
			end
		end
	end

	// Scan payload
	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			idx_row_q <= req_global_row[OFS_W-1:0];
			idx_col_q <= req_global_col[OFS_W-1:0];
		end
		if (cmd.start_read) slot_q <= req_entry_index;
		j_s1 <= k_q;
		if (cmd.scan && v_s1) begin
			prev_row_q <= rrow_s1;
			prev_col_q <= rcol_s1;
		end
		if (row_hit) rc_q <= j_s1 - OA_W'(1);
		if (col_hit) cc_q <= j_s1 - OA_W'(1);
	end

	// Flat grid index
	assign flat_d = FW'(rc_q) * FW'(nc) + FW'(cc_q);

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			flat_q <= flat_d;
			hit_q  <= found_row_q && found_col_q && (32'(flat_d) < MAX_RANKS);
		end
	end

	// Rank table
	always_ff @(posedge clk) begin
		if (rank_we) rank_mem[RA_W'(req_entry_index)] <= req_entry_value[RANK_W-1:0];
		rank_q <= rank_mem[RA_W'(flat_q)];
	end

	assign sts.hit     = hit_q;
	assign sts.rank_ok = (32'(rank_q) < MAX_RANKS);
	assign slot_ok     = (32'(slot_q) < MAX_RANKS);

	// Count table: entries not valid since the last clear read as zero
	assign cnt_addr = cmd.use_slot ? RA_W'(slot_q) : RA_W'(rank_q);

	always_ff @(posedge clk) begin
		if (cmd.cnt_write) cnt_mem[RA_W'(rank_q)] <= cnt_next;
		cnt_rd_q  <= cnt_mem[cnt_addr];
		cvld_rd_q <= cnt_vld_q[cnt_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cmd.clear) begin
			cnt_vld_q <= '0;
		end else if (cmd.cnt_write) begin
			cnt_vld_q[RA_W'(rank_q)] <= 1'b1;
		end
	end

	// Saturating increment
	assign cnt_base = cvld_rd_q ? cnt_rd_q : '0;
	assign cnt_next = (cnt_base == '1) ? cnt_base : cnt_base + COUNT_W'(1);

	// Output register
	assign sts.out_full = out_valid_q && !rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.res_sel)
				RES_MISS: begin
					res_dest_q  <= '0;
					res_row_q   <= '0;
					res_col_q   <= '0;
					res_count_q <= '0;
					res_oor_q   <= 1'b1;
				end
				RES_BADRANK: begin
					res_dest_q  <= rank_q;
					res_row_q   <= CHUNK_W'(rc_q);
					res_col_q   <= CHUNK_W'(cc_q);
					res_count_q <= '0;
					res_oor_q   <= 1'b1;
				end
				RES_COUNT: begin
					res_dest_q  <= rank_q;
					res_row_q   <= CHUNK_W'(rc_q);
					res_col_q   <= CHUNK_W'(cc_q);
					res_count_q <= cnt_next;
					res_oor_q   <= 1'b0;
				end
				RES_READ: begin
					res_dest_q  <= slot_q;
					res_row_q   <= '0;
					res_col_q   <= '0;
					res_count_q <= (slot_ok && cvld_rd_q) ? cnt_rd_q : '0;
					res_oor_q   <= !slot_ok;
				end
				default: ;
			endcase
		end
	end

	assign rsp_valid        = out_valid_q;
	assign rsp_dest_rank    = res_dest_q;
	assign rsp_row_chunk    = res_row_q;
	assign rsp_col_chunk    = res_col_q;
	assign rsp_count_value  = res_count_q;
	assign rsp_out_of_range = res_oor_q;

endmodule
`default_nettype wire

// ===== rtl/core/redistribution_send_count_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// redistribution_send_count_histogram: block distribution owner histogram
// Finds the row and column chunk of each element, looks up its destination
// rank and keeps a saturating per-rank element count.
//
//   Channel  Dir  Handshake     Carries
//   req      in   valid/ready   kind, table_axis, entry_index, entry_value,
//                               global_row, global_col
//   rsp      out  valid/ready   dest_rank, row_chunk, col_chunk, count_value,
//                               out_of_range
//   cfg      in   valid/ready   index, wdata (row_chunks, col_chunks)
//
// Loads, clear and unused kinds finish in ST_IDLE; a count read goes through
// ST_RD and ST_RDOUT. A classify scans max(nr, nc) chunks, nr and nc the clamped
// chunk counts, reading one offset per axis per cycle, then looks up the rank and updates its count when in range.
// Reset zeroes all counts through per-rank valid flags, with no clearing pass;
// offset and rank tables hold nothing until loaded.
// A finished result sits in the output register while the next request is
// taken; a classify or read holds at its last step while that register is full.
// ----------------------------------------------------------------------------
module redistribution_send_count_histogram #(
	parameter int MAX_CHUNKS = rsch_pkg::DEF_MAX_CHUNKS,
	parameter int MAX_RANKS  = rsch_pkg::DEF_MAX_RANKS,
	parameter int INDEX_BITS = rsch_pkg::DEF_INDEX_BITS
) (
	input logic       clk,
	input logic       arst_n,
	rsch_req_if.sink  req,
	rsch_rsp_if.source rsp,
	rsch_cfg_if.sink  cfg
);
	import rsch_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	// Controller
	rsch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	rsch_dpath #(
		.MAX_CHUNKS (MAX_CHUNKS),
		.MAX_RANKS  (MAX_RANKS),
		.INDEX_BITS (INDEX_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_wdata        (cfg.wdata),
		.req_table_axis   (req.table_axis),
		.req_entry_index  (req.entry_index),
		.req_entry_value  (req.entry_value),
		.req_global_row   (req.global_row),
		.req_global_col   (req.global_col),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_dest_rank    (rsp.dest_rank),
		.rsp_row_chunk    (rsp.row_chunk),
		.rsp_col_chunk    (rsp.col_chunk),
		.rsp_count_value  (rsp.count_value),
		.rsp_out_of_range (rsp.out_of_range)
	);

	// A result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(rsp.valid && !rsp.ready))
		else $error("result loaded while output register held a pending transaction");

	// Multi-cycle requests block the request channel on the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.kind == KIND_CLASSIFY || req.kind == KIND_READ))
		|=> !req.ready)
		else $error("request accepted while a classify or read was in progress");

	// Counts are only written for a valid rank that was found
	a_count_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_write |-> (sts.hit && sts.rank_ok && cmd.emit))
		else $error("count written without a valid destination rank");

endmodule
`default_nettype wire
